[rtl/core/redo_log_transaction_controller_defines.svh]
// Assertion macros shared by the RTL. Clock clk_i, reset rst_ni (active low).
`ifndef REDO_LOG_TRANSACTION_CONTROLLER_DEFINES_SVH
`define REDO_LOG_TRANSACTION_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS

// Property that must hold at every edge outside reset
`define RLTC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rltc assertion failed");

// Antecedent at one edge implies consequent at the next
`define RLTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rltc assertion failed");

`else

`define RLTC_ASSERT(lbl, prop)
`define RLTC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[rtl/core/rltc_pkg.sv]
`timescale 1ns / 1ps

package rltc_pkg;

  localparam int unsigned LOG_ENTRIES = 16;
  localparam int unsigned IDX_W = (LOG_ENTRIES > 1) ? $clog2(LOG_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(LOG_ENTRIES + 1);

  localparam int unsigned BLK_W = 24;
  localparam int unsigned CMD_W = 2;
  localparam int unsigned OP_W  = 3;
  localparam int unsigned EIX_W = 5;
  localparam int unsigned STS_W = 2;
  localparam int unsigned REG_W = 1;

  // configuration register indexes
  localparam logic [REG_W-1:0] REG_LOG_START  = 1'b0;
  localparam logic [REG_W-1:0] REG_LOG_REGION = 1'b1;

  // command codes
  localparam logic [CMD_W-1:0] CMD_BEGIN  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMMIT = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_ACK     = 3'd0,
    OP_COPY    = 3'd1,
    OP_HCOUNT  = 3'd2,
    OP_HENTRY  = 3'd3,
    OP_INSTALL = 3'd4
  } op_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK    = 2'd0,
    STS_BUSY  = 2'd1,
    STS_BIG   = 2'd2,
    STS_NOTX  = 2'd3
  } status_e;

  // which result the datapath builds
  typedef enum logic [3:0] {
    EM_ACK_OK,
    EM_ACK_BUSY,
    EM_ACK_BIG,
    EM_ACK_NOTX,
    EM_COPY,
    EM_HCOUNT,
    EM_HENTRY,
    EM_INSTALL,
    EM_HCLEAR
  } emit_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISP,
    ST_SRCH,
    ST_WLOG,
    ST_HENT,
    ST_INST,
    ST_CLR
  } state_e;

  typedef struct packed {
    logic  load;
    logic  idx_clr;
    logic  idx_inc;
    logic  slot_hit;
    logic  slot_new;
    logic  mem_wr;
    logic  set_tx;
    logic  clr_tx;
    logic  cnt_clr;
    logic  emit;
    emit_e kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             in_tx;
    logic             full;
    logic             cnt_zero;
    logic             hit;
    logic             idx_last;
    logic             out_free;
  } dp_stat_t;

  // log data block for a slot, wraps modulo 2^24
  function automatic logic [BLK_W-1:0] log_block(input logic [BLK_W-1:0] start,
                                                 input logic [IDX_W-1:0] slot);
    log_block = start + BLK_W'(slot) + BLK_W'(1);
  endfunction

endpackage

[rtl/core/redo_log_transaction_controller.sv]
`timescale 1ns / 1ps
// Channel   Dir  Handshake               Payload
// in        in   in_valid_i/in_ready_o   command_i, home_sector_i
// out       out  out_valid_o/out_ready_i op_kind_o, source_block_o, dest_block_o,
//                                        entry_index_o, status_o, last_o
// cfg       in   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One request at a time. An ack comes from dispatch; a logged write runs through
// dispatch, an absorption search over at most all logged entries and the log
// write; a commit walks the table twice. The single registered read port of the
// entry table sets the walk rate, one entry per cycle while results are taken.
// Reset clears the open-transaction flag and entry count. A stalled result holds
// the sequencer; the next request is taken once the last result is registered.

module redo_log_transaction_controller import rltc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [CMD_W-1:0] command_i,
  input  logic [BLK_W-1:0] home_sector_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [OP_W-1:0]  op_kind_o,
  output logic [BLK_W-1:0] source_block_o,
  output logic [BLK_W-1:0] dest_block_o,
  output logic [EIX_W-1:0] entry_index_o,
  output logic [STS_W-1:0] status_o,
  output logic             last_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [REG_W-1:0] cfg_index_i,
  input  logic [BLK_W-1:0] cfg_data_i
);

  ctrl_cmd_t ctrl;
  dp_stat_t  stat;

  // config writes go straight into the registers, always accepted
  assign cfg_ready_o = 1'b1;

  // sequencer: dispatch, search, log write, header, install, clear
  rltc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // transaction state, entry table, result register
  rltc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .command_i      (command_i),
    .home_sector_i  (home_sector_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .op_kind_o      (op_kind_o),
    .source_block_o (source_block_o),
    .dest_block_o   (dest_block_o),
    .entry_index_o  (entry_index_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

endmodule

[rtl/core/rltc_ram.sv]
`timescale 1ns / 1ps

module rltc_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/rltc_dp.sv]
`timescale 1ns / 1ps
`include "redo_log_transaction_controller_defines.svh"

module rltc_dp import rltc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctrl_cmd_t        ctrl_i,
  output dp_stat_t         stat_o,
  input  logic [CMD_W-1:0] command_i,
  input  logic [BLK_W-1:0] home_sector_i,
  input  logic             cfg_valid_i,
  input  logic [REG_W-1:0] cfg_index_i,
  input  logic [BLK_W-1:0] cfg_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [OP_W-1:0]  op_kind_o,
  output logic [BLK_W-1:0] source_block_o,
  output logic [BLK_W-1:0] dest_block_o,
  output logic [EIX_W-1:0] entry_index_o,
  output logic [STS_W-1:0] status_o,
  output logic             last_o
);

  logic [BLK_W-1:0] start_q, region_q;
  logic [CMD_W-1:0] cmd_q;
  logic [BLK_W-1:0] sector_q;
  logic             in_tx_q, in_tx_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] slot_q;
  logic [BLK_W-1:0] rdata;
  logic             out_free;

  logic             out_valid_q;
  logic [OP_W-1:0]  op_q, op_d;
  logic [BLK_W-1:0] src_q, src_d, dst_q, dst_d;
  logic [EIX_W-1:0] eix_q, eix_d;
  logic [STS_W-1:0] sts_q, sts_d;
  logic             last_q, last_d;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= '0;
      region_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_LOG_START:  start_q  <= cfg_data_i;
        REG_LOG_REGION: region_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // request latch
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q    <= command_i;
      sector_q <= home_sector_i;
    end
    if (ctrl_i.slot_hit) begin
      slot_q <= idx_q;
    end else if (ctrl_i.slot_new) begin
      slot_q <= count_q[IDX_W-1:0];
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (ctrl_i.idx_clr) begin
      idx_d = '0;
    end else if (ctrl_i.idx_inc) begin
      idx_d = idx_q + IDX_W'(1);
    end
  end

  always_comb begin
    in_tx_d = in_tx_q;
    if (ctrl_i.set_tx) begin
      in_tx_d = 1'b1;
    end else if (ctrl_i.clr_tx) begin
      in_tx_d = 1'b0;
    end
  end

  always_comb begin
    count_d = count_q;
    if (ctrl_i.cnt_clr) begin
      count_d = '0;
    end else if (ctrl_i.mem_wr && (CNT_W'(slot_q) == count_q)) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_tx_q <= 1'b0;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      in_tx_q <= in_tx_d;
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  // entry table; read address follows the next index so data lines up with idx_q
  rltc_ram #(
    .WIDTH (BLK_W),
    .DEPTH (LOG_ENTRIES)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.mem_wr),
    .waddr_i (slot_q),
    .wdata_i (sector_q),
    .raddr_i (idx_d),
    .rdata_o (rdata)
  );

  assign out_free = !out_valid_q || out_ready_i;

  assign stat_o.cmd      = cmd_q;
  assign stat_o.in_tx    = in_tx_q;
  assign stat_o.full     = (count_q >= CNT_W'(LOG_ENTRIES)) ||
                           ((BLK_W + 1)'(count_q) + (BLK_W + 1)'(1) >=
                            (BLK_W + 1)'(region_q));
  assign stat_o.cnt_zero = (count_q == '0);
  assign stat_o.hit      = (rdata == sector_q);
  assign stat_o.idx_last = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
  assign stat_o.out_free = out_free;

  // result builder
  always_comb begin
    op_d   = OP_ACK;
    src_d  = '0;
    dst_d  = '0;
    eix_d  = '0;
    sts_d  = STS_OK;
    last_d = 1'b0;
    unique case (ctrl_i.kind)
      EM_ACK_OK: begin
        last_d = 1'b1;
      end
      EM_ACK_BUSY: begin
        sts_d  = STS_BUSY;
        last_d = 1'b1;
      end
      EM_ACK_BIG: begin
        sts_d  = STS_BIG;
        last_d = 1'b1;
      end
      EM_ACK_NOTX: begin
        sts_d  = STS_NOTX;
        last_d = 1'b1;
      end
      EM_COPY: begin
        op_d   = OP_COPY;
        src_d  = sector_q;
        dst_d  = log_block(start_q, slot_q);
        eix_d  = EIX_W'(slot_q);
        last_d = 1'b1;
      end
      EM_HCOUNT: begin
        op_d  = OP_HCOUNT;
        dst_d = start_q;
        eix_d = EIX_W'(count_q);
      end
      EM_HENTRY: begin
        op_d  = OP_HENTRY;
        dst_d = rdata;
        eix_d = EIX_W'(idx_q);
      end
      EM_INSTALL: begin
        op_d  = OP_INSTALL;
        src_d = log_block(start_q, idx_q);
        dst_d = rdata;
        eix_d = EIX_W'(idx_q);
      end
      EM_HCLEAR: begin
        op_d   = OP_HCOUNT;
        dst_d  = start_q;
        last_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit) begin
      op_q   <= op_d;
      src_q  <= src_d;
      dst_q  <= dst_d;
      eix_q  <= eix_d;
      sts_q  <= sts_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign op_kind_o      = op_q;
  assign source_block_o = src_q;
  assign dest_block_o   = dst_q;
  assign entry_index_o  = eix_q;
  assign status_o       = sts_q;
  assign last_o         = last_q;

  `RLTC_ASSERT(a_count_bound, count_q <= CNT_W'(LOG_ENTRIES))
  `RLTC_ASSERT(a_wr_in_tx, !ctrl_i.mem_wr || in_tx_q)
  `RLTC_ASSERT(a_emit_free, !ctrl_i.emit || out_free)

endmodule

[rtl/core/rltc_ctrl.sv]
`timescale 1ns / 1ps
`include "redo_log_transaction_controller_defines.svh"

module rltc_ctrl import rltc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t ctrl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DISP;
      end
      ST_DISP: begin
        unique case (stat_i.cmd)
          CMD_WRITE: begin
            if (stat_i.full || !stat_i.in_tx) begin
              if (stat_i.out_free) state_d = ST_IDLE;
            end else if (stat_i.cnt_zero) begin
              state_d = ST_WLOG;
            end else begin
              state_d = ST_SRCH;
            end
          end
          CMD_COMMIT: begin
            if (stat_i.out_free) state_d = stat_i.cnt_zero ? ST_IDLE : ST_HENT;
          end
          default: begin
            if (stat_i.out_free) state_d = ST_IDLE;
          end
        endcase
      end
      ST_SRCH: begin
        if (stat_i.hit || stat_i.idx_last) state_d = ST_WLOG;
      end
      ST_WLOG: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      ST_HENT: begin
        if (stat_i.out_free && stat_i.idx_last) state_d = ST_INST;
      end
      ST_INST: begin
        if (stat_i.out_free && stat_i.idx_last) state_d = ST_CLR;
      end
      ST_CLR: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl_o     = '0;
    ctrl_o.kind = EM_ACK_OK;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        ctrl_o.load = in_valid_i;
      end
      ST_DISP: begin
        unique case (stat_i.cmd)
          CMD_BEGIN: begin
            ctrl_o.emit   = stat_i.out_free;
            ctrl_o.kind   = stat_i.in_tx ? EM_ACK_BUSY : EM_ACK_OK;
            ctrl_o.set_tx = stat_i.out_free && !stat_i.in_tx;
          end
          CMD_WRITE: begin
            if (stat_i.full) begin
              ctrl_o.emit = stat_i.out_free;
              ctrl_o.kind = EM_ACK_BIG;
            end else if (!stat_i.in_tx) begin
              ctrl_o.emit = stat_i.out_free;
              ctrl_o.kind = EM_ACK_NOTX;
            end else if (stat_i.cnt_zero) begin
              ctrl_o.slot_new = 1'b1;
            end else begin
              ctrl_o.idx_clr = 1'b1;
            end
          end
          CMD_COMMIT: begin
            ctrl_o.emit = stat_i.out_free;
            if (stat_i.cnt_zero) begin
              ctrl_o.kind   = EM_ACK_OK;
              ctrl_o.clr_tx = stat_i.out_free;
            end else begin
              ctrl_o.kind    = EM_HCOUNT;
              ctrl_o.idx_clr = stat_i.out_free;
            end
          end
          default: begin
            ctrl_o.emit = stat_i.out_free;
            ctrl_o.kind = EM_ACK_OK;
          end
        endcase
      end
      ST_SRCH: begin
        if (stat_i.hit) begin
          ctrl_o.slot_hit = 1'b1;
        end else if (stat_i.idx_last) begin
          ctrl_o.slot_new = 1'b1;
        end else begin
          ctrl_o.idx_inc = 1'b1;
        end
      end
      ST_WLOG: begin
        ctrl_o.emit   = stat_i.out_free;
        ctrl_o.kind   = EM_COPY;
        ctrl_o.mem_wr = stat_i.out_free;
      end
      ST_HENT: begin
        ctrl_o.emit    = stat_i.out_free;
        ctrl_o.kind    = EM_HENTRY;
        ctrl_o.idx_clr = stat_i.out_free && stat_i.idx_last;
        ctrl_o.idx_inc = stat_i.out_free && !stat_i.idx_last;
      end
      ST_INST: begin
        ctrl_o.emit    = stat_i.out_free;
        ctrl_o.kind    = EM_INSTALL;
        ctrl_o.idx_inc = stat_i.out_free && !stat_i.idx_last;
      end
      ST_CLR: begin
        ctrl_o.emit    = stat_i.out_free;
        ctrl_o.kind    = EM_HCLEAR;
        ctrl_o.clr_tx  = stat_i.out_free;
        ctrl_o.cnt_clr = stat_i.out_free;
      end
      default: ;
    endcase
  end

  `RLTC_ASSERT_NEXT(a_load_disp, ctrl_o.load, state_q == ST_DISP)
  `RLTC_ASSERT(a_load_idle, !ctrl_o.load || state_q == ST_IDLE)

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// Request/result check of the redo-log controller.
// Requests go in on the in channel and each one is fed to an inline predictor
// as it is accepted. The predictor queues the disk operations that request must
// produce. A monitor pops the queue for every result taken from the out channel.
// Log geometry is written over the cfg channel only when the block is idle.
// Phases cycle through the sender and receiver idling patterns.

module testbench;
  import rltc_pkg::*;

  // spare command code, no name in the package; the block just acknowledges it
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  localparam int unsigned ITEMS_PER_PHASE = 42;
  localparam int unsigned SHOW_MAX        = 10;

  logic             clk_i;
  logic             rst_ni        = 1'b0;
  logic             in_valid_i    = 1'b0;
  logic             in_ready_o;
  logic [CMD_W-1:0] command_i     = CMD_BEGIN;
  logic [BLK_W-1:0] home_sector_i = '0;
  logic             out_valid_o;
  logic             out_ready_i   = 1'b0;
  logic [OP_W-1:0]  op_kind_o;
  logic [BLK_W-1:0] source_block_o;
  logic [BLK_W-1:0] dest_block_o;
  logic [EIX_W-1:0] entry_index_o;
  logic [STS_W-1:0] status_o;
  logic             last_o;
  logic             cfg_valid_i   = 1'b0;
  logic             cfg_ready_o;
  logic [REG_W-1:0] cfg_index_i   = REG_LOG_START;
  logic [BLK_W-1:0] cfg_data_i    = '0;

  // one disk operation as it leaves the block
  typedef struct {
    op_e              op;
    logic [BLK_W-1:0] src;
    logic [BLK_W-1:0] dst;
    logic [EIX_W-1:0] idx;
    status_e          sts;
    logic             last;
  } disk_op_t;

  disk_op_t pending_ops[$];

  // predictor copy of the block's configuration and transaction state
  logic [BLK_W-1:0] log_head;
  int unsigned      log_blocks;
  bit               tx_open;
  int unsigned      n_entries;
  logic [BLK_W-1:0] logged_sector [LOG_ENTRIES];

  int unsigned idle_pct;   // chance the sender idles before a request
  int unsigned stall_pct;  // chance the receiver holds off a result
  int unsigned fail_count;

  redo_log_transaction_controller u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .home_sector_i (home_sector_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .op_kind_o     (op_kind_o),
    .source_block_o(source_block_o),
    .dest_block_o  (dest_block_o),
    .entry_index_o (entry_index_o),
    .status_o      (status_o),
    .last_o        (last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop, far beyond the slowest correct run: 34 results per request,
  // each held off by a long receiver stall, plus sender gaps.
  initial begin
    #100_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // log data block for a table slot; 24-bit wrap is intended
  function automatic logic [BLK_W-1:0] data_block(input int unsigned slot);
    data_block = log_head + BLK_W'(slot) + BLK_W'(1);
  endfunction

  function automatic void queue_op(input op_e op, input logic [BLK_W-1:0] src,
                                   input logic [BLK_W-1:0] dst, input int unsigned idx,
                                   input status_e sts, input logic last);
    disk_op_t d;
    d.op   = op;
    d.src  = src;
    d.dst  = dst;
    d.idx  = EIX_W'(idx);
    d.sts  = sts;
    d.last = last;
    pending_ops.push_back(d);
  endfunction

  // Disk operations caused by one accepted request
  function automatic void predict_ops(input logic [CMD_W-1:0] cmd,
                                      input logic [BLK_W-1:0] sector);
    int unsigned slot;
    case (cmd)
      CMD_BEGIN: begin
        if (tx_open) begin
          queue_op(OP_ACK, '0, '0, 0, STS_BUSY, 1'b1);
        end else begin
          tx_open = 1'b1;
          queue_op(OP_ACK, '0, '0, 0, STS_OK, 1'b1);
        end
      end
      CMD_WRITE: begin
        // full check comes first, even for a sector that would be absorbed
        if (n_entries >= LOG_ENTRIES || n_entries + 1 >= log_blocks) begin
          queue_op(OP_ACK, '0, '0, 0, STS_BIG, 1'b1);
        end else if (!tx_open) begin
          queue_op(OP_ACK, '0, '0, 0, STS_NOTX, 1'b1);
        end else begin
          slot = n_entries;
          for (int unsigned i = 0; i < n_entries; i++) begin
            if (logged_sector[i] == sector) begin
              slot = i;
              break;
            end
          end
          logged_sector[slot] = sector;
          if (slot == n_entries) n_entries++;
          queue_op(OP_COPY, sector, data_block(slot), slot, STS_OK, 1'b1);
        end
      end
      CMD_COMMIT: begin
        if (n_entries > 0) begin
          queue_op(OP_HCOUNT, '0, log_head, n_entries, STS_OK, 1'b0);
          for (int unsigned i = 0; i < n_entries; i++)
            queue_op(OP_HENTRY, '0, logged_sector[i], i, STS_OK, 1'b0);
          for (int unsigned i = 0; i < n_entries; i++)
            queue_op(OP_INSTALL, data_block(i), logged_sector[i], i, STS_OK, 1'b0);
          queue_op(OP_HCOUNT, '0, log_head, 0, STS_OK, 1'b1);  // cleared header
          n_entries = 0;
        end else begin
          queue_op(OP_ACK, '0, '0, 0, STS_OK, 1'b1);
        end
        tx_open = 1'b0;
      end
      default: begin
        queue_op(OP_ACK, '0, '0, 0, STS_OK, 1'b1);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and the in-order check
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin : check_results
    disk_op_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_ops.size() == 0) begin
        fail_count++;
        if (fail_count <= SHOW_MAX)
          $display("%0t: unexpected result op=%0d src=%h dst=%h idx=%0d sts=%0d last=%0d",
                   $realtime, op_kind_o, source_block_o, dest_block_o, entry_index_o,
                   status_o, last_o);
      end else begin
        want = pending_ops.pop_front();
        if (op_kind_o !== want.op || source_block_o !== want.src ||
            dest_block_o !== want.dst || entry_index_o !== want.idx ||
            status_o !== want.sts || last_o !== want.last) begin
          fail_count++;
          if (fail_count <= SHOW_MAX) begin
            $display("%0t: mismatch, expected op=%0d src=%h dst=%h idx=%0d sts=%0d last=%0d",
                     $realtime, want.op, want.src, want.dst, want.idx, want.sts, want.last);
            $display("%0t:           got      op=%0d src=%h dst=%h idx=%0d sts=%0d last=%0d",
                     $realtime, op_kind_o, source_block_o, dest_block_o, entry_index_o,
                     status_o, last_o);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Valid is left high after acceptance so back-to-back requests never lower
  // and raise it in the same step; it drops only for a gap or a drain.
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [BLK_W-1:0] sector);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    home_sector_i <= sector;
    do @(posedge clk_i); while (!in_ready_o);
    predict_ops(cmd, sector);
  endtask

  // Let every expected result out; the block is idle afterwards
  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_ops.size() != 0) @(posedge clk_i);
  endtask

  // Both registers in one go, valid held across the two requests
  task automatic set_log_geometry(input logic [BLK_W-1:0] start,
                                  input logic [BLK_W-1:0] blocks);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_LOG_START;
    cfg_data_i  <= start;
    do @(posedge clk_i); while (!cfg_ready_o);
    log_head    = start;
    cfg_index_i <= REG_LOG_REGION;
    cfg_data_i  <= blocks;
    do @(posedge clk_i); while (!cfg_ready_o);
    log_blocks  = 32'(blocks);
    cfg_valid_i <= 1'b0;
  endtask

  // 0 none, 1 sender idles, 2 receiver stalls, 3 both
  task automatic set_idling(input int unsigned mode);
    case (mode)
      1:       begin idle_pct = 48; stall_pct = 0;  end
      2:       begin idle_pct = 0;  stall_pct = 48; end
      3:       begin idle_pct = 22; stall_pct = 22; end
      default: begin idle_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Straight out of reset the region is 0 blocks, so any write is too big,
  // and that is reported ahead of the missing transaction.
  task automatic test_reset_geometry;
    send_request(CMD_WRITE, 24'h123456);
    drain();
  endtask

  task automatic test_no_transaction;
    set_log_geometry(24'hFFFFF0, 24'd17);
    send_request(CMD_WRITE, 24'hFFFFFF);   // write outside a transaction
    send_request(CMD_COMMIT, 24'h000000);  // commit with nothing open
    send_request(CMD_SPARE, 24'hA5A5A5);
    drain();
  endtask

  task automatic test_begin_busy;
    send_request(CMD_BEGIN, 24'h000000);
    send_request(CMD_BEGIN, 24'hFFFFFF);   // second claim: busy
    send_request(CMD_COMMIT, 24'h5A5A5A);  // empty commit closes it
    drain();
  endtask

  // Fill all sixteen slots with one absorbed write on the way, overflow with a
  // new and with an absorbed sector, then commit. Start 0xFFFFF0 makes the
  // last slot's log block wrap to 0.
  task automatic test_fill_and_commit;
    send_request(CMD_BEGIN, 24'h000000);
    send_request(CMD_WRITE, 24'h000000);
    send_request(CMD_WRITE, 24'hFFFFFF);
    send_request(CMD_WRITE, 24'h000000);
    for (int i = 0; i < 14; i++) send_request(CMD_WRITE, BLK_W'(1) << i);
    send_request(CMD_WRITE, 24'hABCDEF);
    send_request(CMD_WRITE, 24'hFFFFFF);
    send_request(CMD_COMMIT, 24'h000000);
    drain();
  endtask

  // Mostly well-formed transactions over a small sector pool so that absorption
  // and the full limit are hit often; the rest is random noise.
  task automatic run_random_traffic(input int unsigned n_items);
    logic [BLK_W-1:0] pool [20];
    int unsigned      sent;
    int unsigned      pool_n;
    int unsigned      n_writes;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 80) begin
        pool_n   = $urandom_range(20, 1);
        n_writes = $urandom_range(18, 0);
        foreach (pool[i]) pool[i] = BLK_W'($urandom);
        send_request(CMD_BEGIN, BLK_W'($urandom));
        for (int unsigned w = 0; w < n_writes; w++)
          send_request(CMD_WRITE, pool[$urandom_range(pool_n - 1, 0)]);
        send_request(CMD_COMMIT, BLK_W'($urandom));
        sent += n_writes + 2;
      end else begin
        send_request(CMD_W'($urandom_range(3, 0)), BLK_W'($urandom));
        sent++;
      end
    end
    drain();
  endtask

  task automatic test_random_phases;
    logic [BLK_W-1:0] start;
    logic [BLK_W-1:0] blocks;
    for (int unsigned p = 0; p < 8; p++) begin
      start = BLK_W'($urandom);
      case (p)
        0:       begin start = 24'h000000; blocks = 24'd17; end
        1:       begin start = 24'hFFFFFF; blocks = 24'hFFFFFF; end
        2:       blocks = 24'd5;
        3:       blocks = 24'd0;
        4:       begin start = 24'hFFFFF8; blocks = 24'd18; end
        5:       blocks = 24'd1;
        6:       blocks = 24'd2;
        default: blocks = BLK_W'($urandom_range(24, 3));
      endcase
      set_idling(p % 4);
      set_log_geometry(start, blocks);
      run_random_traffic(ITEMS_PER_PHASE);
    end
  endtask

  initial begin
    log_head   = '0;
    log_blocks = 0;
    tx_open    = 1'b0;
    n_entries  = 0;
    fail_count = 0;
    set_idling(0);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_geometry();
    set_idling(3);
    test_no_transaction();
    test_begin_busy();
    test_fill_and_commit();
    test_random_phases();

    // settle: nothing more may come out
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
